[hw/rtl/vln_pkg.sv]
// Shared widths, stage counts and sideband types for the vector length block.
package vln_pkg;

    localparam int COMP_W      = 32;
    localparam int SUM_W       = 2 * COMP_W;
    localparam int ROOT_W      = COMP_W;
    localparam int FRAC_W      = 30;
    localparam int QUO_W       = FRAC_W + 1;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = QUO_W;

    // Travels with the sum of squares through the root pipeline.
    typedef struct packed {
        logic [COMP_W-1:0] ax;
        logic [COMP_W-1:0] ay;
        logic [COMP_W-1:0] az;
        logic              nx;
        logic              ny;
        logic              nz;
        logic              zero;
    } t_sq_side;

    // Travels beside the three dividers.
    typedef struct packed {
        logic [ROOT_W-1:0] len;
        logic              nx;
        logic              ny;
        logic              nz;
        logic              zero;
    } t_dv_side;

endpackage

[hw/rtl/vector3_length_normalize.sv]
// Top level: 3-D vector length and unit vector, fully pipelined stream block.
//
// Takes one vector (three signed Q16.16 components) per word and returns its
// floored Euclidean length (unsigned Q16.16) and the unit vector (signed
// Q1.30, each component divided by the floored length, truncated toward
// zero). A zero vector returns length 0, a zero unit vector and tuser = 1.
// One vector is accepted every cycle while the skid buffer is free. A vector
// passes abs, square, sum, a 32-stage square root (one root bit per stage),
// three 31-stage dividers in parallel (one quotient bit per stage), a sign
// stage and the output register. A one-word skid buffer behind the output
// register keeps the input open while a finished word waits.
module vector3_length_normalize
    import vln_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // comp_x, comp_y, comp_z
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,   // magnitude, unit_x, unit_y, unit_z
    output logic         o_m_tuser    // zero_length
);

    logic w_en;

    // stage 0: magnitudes and signs
    logic              r_s0_v;
    t_sq_side          r_s0;
    // stage 1: squares
    logic              r_s1_v;
    t_sq_side          r_s1_side;
    logic [SUM_W-1:0]  r_sqx, r_sqy, r_sqz;
    // stage 2: sum of squares
    logic              r_s2_v;
    t_sq_side          r_s2_side;
    logic [SUM_W-1:0]  r_sum;

    logic              w_rt_v;
    logic [ROOT_W-1:0] w_root;
    t_sq_side          w_rt_side;

    logic [QUO_W-1:0]  w_qx, w_qy, w_qz;
    t_dv_side          w_dv_in;
    t_dv_side          r_dv_side [0:DIV_STAGES];
    logic [DIV_STAGES:0] r_dv_v;

    logic              r_t_v;
    logic [127:0]      r_t_data;
    logic              r_t_zero;

    logic              r_o_v;
    logic [127:0]      r_o_data;
    logic              r_o_zero;
    logic              r_sk_v;
    logic [127:0]      r_sk_data;
    logic              r_sk_zero;

    // the whole pipeline moves whenever the skid buffer is free
    assign w_en       = !r_sk_v;
    assign o_s_tready = w_en;

    // ---- stage 0: absolute values ----
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0.nx   <= i_s_tdata[31];
            r_s0.ny   <= i_s_tdata[63];
            r_s0.nz   <= i_s_tdata[95];
            r_s0.ax   <= i_s_tdata[31] ? (32'd0 - i_s_tdata[31:0])  : i_s_tdata[31:0];
            r_s0.ay   <= i_s_tdata[63] ? (32'd0 - i_s_tdata[63:32]) : i_s_tdata[63:32];
            r_s0.az   <= i_s_tdata[95] ? (32'd0 - i_s_tdata[95:64]) : i_s_tdata[95:64];
            r_s0.zero <= (i_s_tdata == 96'd0);
        end
    end

    // ---- stage 1: squares, one multiplier per component ----
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_side <= r_s0;
            r_sqx     <= SUM_W'(r_s0.ax) * SUM_W'(r_s0.ax);
            r_sqy     <= SUM_W'(r_s0.ay) * SUM_W'(r_s0.ay);
            r_sqz     <= SUM_W'(r_s0.az) * SUM_W'(r_s0.az);
        end
    end

    // ---- stage 2: sum; at most 3 * 2^62, so 64 bits hold it exactly ----
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_side <= r_s1_side;
            r_sum     <= r_sqx + r_sqy + r_sqz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v <= i_s_tvalid;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
        end
    end

    // ---- floored square root ----
    vln_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_v),
        .i_rad   (r_sum),
        .i_side  (r_s2_side),
        .o_valid (w_rt_v),
        .o_root  (w_root),
        .o_side  (w_rt_side)
    );

    // ---- three dividers; the zero vector's quotients are junk and get masked ----
    vln_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_rt_side.ax),
        .i_den (w_root),
        .o_quo (w_qx)
    );

    vln_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_rt_side.ay),
        .i_den (w_root),
        .o_quo (w_qy)
    );

    vln_div u_div_z (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_rt_side.az),
        .i_den (w_root),
        .o_quo (w_qz)
    );

    // carry length, signs and the zero flag alongside the dividers
    assign w_dv_in.len  = w_root;
    assign w_dv_in.nx   = w_rt_side.nx;
    assign w_dv_in.ny   = w_rt_side.ny;
    assign w_dv_in.nz   = w_rt_side.nz;
    assign w_dv_in.zero = w_rt_side.zero;
    assign r_dv_side[0] = w_dv_in;
    assign r_dv_v[0]    = w_rt_v;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_dv_delay
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_side[k+1] <= r_dv_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end
    end

    // ---- sign stage: negate, mask the zero vector, pack the word ----
    function automatic logic [COMP_W-1:0] signed_unit(
        input logic [QUO_W-1:0] quo,
        input logic             neg,
        input logic             zero
    );
        logic [COMP_W-1:0] ext;
        ext = COMP_W'(quo);
        if (zero) begin
            return '0;
        end
        return neg ? (COMP_W'(0) - ext) : ext;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_zero          <= r_dv_side[DIV_STAGES].zero;
            r_t_data[31:0]    <= r_dv_side[DIV_STAGES].len;
            r_t_data[63:32]   <= signed_unit(w_qx, r_dv_side[DIV_STAGES].nx,
                                             r_dv_side[DIV_STAGES].zero);
            r_t_data[95:64]   <= signed_unit(w_qy, r_dv_side[DIV_STAGES].ny,
                                             r_dv_side[DIV_STAGES].zero);
            r_t_data[127:96]  <= signed_unit(w_qz, r_dv_side[DIV_STAGES].nz,
                                             r_dv_side[DIV_STAGES].zero);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
        end else if (w_en) begin
            r_t_v <= r_dv_v[DIV_STAGES];
        end
    end

    // ---- output register and skid word ----
    // While the pipeline moves, the tail word goes to the output register if
    // that one is free or draining, else into the skid. A full skid freezes
    // the pipeline and refills the output register once it drains.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_t_v && (!r_o_v || i_m_tready)) begin
                r_o_data <= r_t_data;
                r_o_zero <= r_t_zero;
            end
            if (r_t_v && r_o_v && !i_m_tready) begin
                r_sk_data <= r_t_data;
                r_sk_zero <= r_t_zero;
            end
        end else if (i_m_tready) begin
            r_o_data <= r_sk_data;
            r_o_zero <= r_sk_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (w_en) begin
            if (r_t_v) begin
                r_o_v  <= 1'b1;
                r_sk_v <= r_o_v && !i_m_tready;
            end else if (i_m_tready) begin
                r_o_v  <= 1'b0;
            end
        end else if (i_m_tready) begin
            r_sk_v <= 1'b0;
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_zero;

    // ---- checks ----
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_o_v)
        else $error("skid word held with no output word");

    a_zero_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 128'd0))
        else $error("zero vector with nonzero length or unit");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[31:0] != 32'd0))
        else $error("nonzero vector with zero length");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && r_t_v) |=> (r_t_v && $stable(r_t_data)))
        else $error("tail word changed while the pipeline was frozen");

endmodule

[hw/rtl/vln_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module vln_sqrt
    import vln_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SUM_W-1:0]  i_rad,
    input  t_sq_side          i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_sq_side          o_side
);

    // index 0 is the stage input, index s+1 the register after stage s
    logic [ROOT_W+2:0]  r_rem  [0:SQRT_STAGES];
    logic [ROOT_W-1:0]  r_root [0:SQRT_STAGES];
    logic [SUM_W-1:0]   r_rad  [0:SQRT_STAGES];
    t_sq_side           r_side [0:SQRT_STAGES];
    logic [SQRT_STAGES:0] r_v;

    assign r_rem[0]  = '0;
    assign r_root[0] = '0;
    assign r_rad[0]  = i_rad;
    assign r_side[0] = i_side;
    assign r_v[0]    = i_valid;

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        logic [ROOT_W+2:0] w_shift;
        logic [ROOT_W+2:0] w_trial;

        assign w_shift = {r_rem[s][ROOT_W:0], r_rad[s][SUM_W-1 -: 2]};
        assign w_trial = {1'b0, r_root[s], 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s+1]  <= {r_rad[s][SUM_W-3:0], 2'b00};
                r_side[s+1] <= r_side[s];
                if (w_shift >= w_trial) begin
                    r_rem[s+1]  <= w_shift - w_trial;
                    r_root[s+1] <= {r_root[s][ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[s+1]  <= w_shift;
                    r_root[s+1] <= {r_root[s][ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    assign o_valid = r_v[SQRT_STAGES];
    assign o_root  = r_root[SQRT_STAGES];
    assign o_side  = r_side[SQRT_STAGES];

endmodule

[hw/rtl/vln_div.sv]
// Pipelined restoring divider: (num << 30) / den, one quotient bit per stage.
module vln_div
    import vln_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [COMP_W-1:0] i_num,
    input  logic [ROOT_W-1:0] i_den,
    output logic [QUO_W-1:0]  o_quo
);

    // num <= den, so the quotient fits in QUO_W bits and the partial
    // remainder stays below den
    logic [ROOT_W:0]   r_rem [0:DIV_STAGES];
    logic [QUO_W-1:0]  r_quo [0:DIV_STAGES];
    logic [ROOT_W-1:0] r_den [0:DIV_STAGES];
    logic              r_lsb [0:DIV_STAGES];

    assign r_rem[0] = {2'b00, i_num[COMP_W-1:1]};
    assign r_quo[0] = '0;
    assign r_den[0] = i_den;
    assign r_lsb[0] = i_num[0];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [ROOT_W:0] w_shift;

        // only the first step brings in a dividend bit; the rest are zeros
        assign w_shift = {r_rem[k][ROOT_W-1:0], (k == 0) ? r_lsb[k] : 1'b0};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k+1] <= r_den[k];
                r_lsb[k+1] <= 1'b0;
                if (w_shift >= {1'b0, r_den[k]}) begin
                    r_rem[k+1] <= w_shift - {1'b0, r_den[k]};
                    r_quo[k+1] <= {r_quo[k][QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= w_shift;
                    r_quo[k+1] <= {r_quo[k][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES];

endmodule
